>>> rtl/dssa_pkg.sv
`timescale 1ns / 1ps

package dssa_pkg;

   typedef enum logic [1:0] {
      ACT_SCALAR = 2'd0,
      ACT_LANE   = 2'd1,
      ACT_SAT    = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      MODE_PLAIN = 2'd0,
      MODE_SAT   = 2'd1,
      MODE_HALVE = 2'd2
   } lane_mode_type;

   localparam logic [1:0] XCH_NONE = 2'd0;
   localparam logic [1:0] XCH_ASX  = 2'd1;
   localparam logic [1:0] XCH_SAX  = 2'd2;

   // Per-stage load strobes from the handshake controller.
   typedef struct packed {
      logic load1;
      logic load2;
      logic load3;
   } pipe_ctl_type;

   // Exact lane sum/difference, two guard bits above the lane width.
   function automatic logic [9:0] byte_raw(input logic [7:0] a, input logic [7:0] b,
                                           input logic uns, input logic sub);
      logic [9:0] ea;
      logic [9:0] eb;
      ea = uns ? {2'b00, a} : {{2{a[7]}}, a};
      eb = uns ? {2'b00, b} : {{2{b[7]}}, b};
      return sub ? (ea - eb) : (ea + eb);
   endfunction

   function automatic logic [17:0] half_raw(input logic [15:0] a, input logic [15:0] b,
                                            input logic uns, input logic sub);
      logic [17:0] ea;
      logic [17:0] eb;
      ea = uns ? {2'b00, a} : {{2{a[15]}}, a};
      eb = uns ? {2'b00, b} : {{2{b[15]}}, b};
      return sub ? (ea - eb) : (ea + eb);
   endfunction

   // Returns {ge, lane_result}.
   function automatic logic [8:0] byte_fin(input logic [9:0] raw, input logic uns,
                                           input logic sub, input lane_mode_type mode);
      logic       ge;
      logic [7:0] r;
      ge = (uns && !sub) ? raw[8] : !raw[9];
      unique case (mode)
         MODE_HALVE: r = raw[8:1];
         MODE_SAT: begin
            if (uns) begin
               r = raw[9] ? 8'h00 : (raw[8] ? 8'hFF : raw[7:0]);
            end else begin
               r = (raw[8] != raw[7]) ? (raw[9] ? 8'h80 : 8'h7F) : raw[7:0];
            end
         end
         default: r = raw[7:0];
      endcase
      return {ge, r};
   endfunction

   function automatic logic [16:0] half_fin(input logic [17:0] raw, input logic uns,
                                            input logic sub, input lane_mode_type mode);
      logic        ge;
      logic [15:0] r;
      ge = (uns && !sub) ? raw[16] : !raw[17];
      unique case (mode)
         MODE_HALVE: r = raw[16:1];
         MODE_SAT: begin
            if (uns) begin
               r = raw[17] ? 16'h0000 : (raw[16] ? 16'hFFFF : raw[15:0]);
            end else begin
               r = (raw[16] != raw[15]) ? (raw[17] ? 16'h8000 : 16'h7FFF) : raw[15:0];
            end
         end
         default: r = raw[15:0];
      endcase
      return {ge, r};
   endfunction

endpackage

>>> rtl/dssa_pipe_ctl.sv
`timescale 1ns / 1ps

module dssa_pipe_ctl import dssa_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output pipe_ctl_type ctl
);

   logic v1_ff, v2_ff, v3_ff;
   logic v1_in, v2_in, v3_in;
   logic rdy1, rdy2, rdy3;

   // A stage takes new data when empty or when its content moves on.
   assign rdy3 = !v3_ff || rsp_ready;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;

   assign v1_in = rdy1 ? req_valid : v1_ff;
   assign v2_in = rdy2 ? v1_ff : v2_ff;
   assign v3_in = rdy3 ? v2_ff : v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   assign req_ready = rdy1;
   assign rsp_valid = v3_ff;
   assign ctl.load1 = rdy1;
   assign ctl.load2 = rdy2;
   assign ctl.load3 = rdy3;

endmodule

>>> rtl/dsp_saturating_simd_alu.sv
`timescale 1ns / 1ps
// Three-stage saturating SIMD ALU: decode/operand prep, lane adders and
// saturation compares, clamp/select into the output register.
// A transaction passes through the stage 1, stage 2 and output registers to rsp_valid.
// Throughput: one transaction per cycle; each stage holds under backpressure.
// Reset (synchronous, active high) clears the stage valid bits only.
module dsp_saturating_simd_alu import dssa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [31:0] req_operand_a,
   input  logic [31:0] req_operand_b,
   input  logic        req_subtract,
   input  logic        req_doubling,
   input  logic        req_byte_lanes,
   input  logic        req_unsigned_lanes,
   input  logic [1:0]  req_lane_mode,
   input  logic [1:0]  req_exchange,
   input  logic [5:0]  req_sat_bits,
   input  logic        req_halfword_saturate,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_result,
   output logic [3:0]  rsp_ge_flags,
   output logic        rsp_ge_written
);

   pipe_ctl_type ctl;

   dssa_pipe_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .ctl       (ctl)
   );

   // ------------------------------------------------------------------
   // Stage 1: decode, exchange swap, doubling saturation, clamp bounds
   // ------------------------------------------------------------------
   action_type    s1_act_ff,   s1_act_in;
   lane_mode_type s1_mode_ff,  s1_mode_in;
   logic          s1_uns_ff,   s1_uns_in;
   logic          s1_sub_ff;
   logic          s1_sub_lo_ff, s1_sub_lo_in;
   logic          s1_sub_hi_ff, s1_sub_hi_in;
   logic          s1_half_ff,  s1_half_in;    // 16-bit lanes
   logic          s1_hsat_ff;
   logic [31:0]   s1_a_ff;
   logic [31:0]   s1_b_ff;                    // raw operand_b (saturate)
   logic [31:0]   s1_sb_ff,    s1_sb_in;      // scalar addend
   logic [31:0]   s1_lb_ff,    s1_lb_in;      // lane operand b, swapped for exchange
   logic [32:0]   s1_hi_ff,    s1_hi_in;      // saturate upper bound, signed
   logic [32:0]   s1_lo_ff,    s1_lo_in;
   logic [1:0]    xch;
   logic [4:0]    sat_k;

   always_comb begin
      s1_act_in  = action_type'(req_action);
      s1_mode_in = (req_lane_mode == 2'd3) ? MODE_PLAIN : lane_mode_type'(req_lane_mode);
      s1_uns_in  = req_unsigned_lanes;
      xch        = (req_exchange == 2'd3) ? XCH_NONE : req_exchange;

      if (xch == XCH_NONE) begin
         s1_half_in   = !req_byte_lanes;
         s1_sub_lo_in = req_subtract;
         s1_sub_hi_in = req_subtract;
         s1_lb_in     = req_operand_b;
      end else begin
         s1_half_in   = 1'b1;
         s1_sub_lo_in = (xch == XCH_ASX);
         s1_sub_hi_in = (xch == XCH_SAX);
         s1_lb_in     = {req_operand_b[15:0], req_operand_b[31:16]};
      end

      // Doubling: signed saturation of 2*b
      if (req_doubling) begin
         if (req_operand_b[31] != req_operand_b[30]) begin
            s1_sb_in = req_operand_b[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
         end else begin
            s1_sb_in = {req_operand_b[30:0], 1'b0};
         end
      end else begin
         s1_sb_in = req_operand_b;
      end

      // Bound exponent: unsigned hi = 2^n-1 (n<=31); signed hi = 2^(n-1)-1 (n in 1..32)
      if (req_unsigned_lanes) begin
         sat_k = (req_sat_bits > 6'd31) ? 5'd31 : req_sat_bits[4:0];
      end else if (req_sat_bits == 6'd0) begin
         sat_k = 5'd0;
      end else if (req_sat_bits > 6'd32) begin
         sat_k = 5'd31;
      end else begin
         sat_k = 5'(req_sat_bits - 6'd1);
      end
      s1_hi_in = (33'd1 << sat_k) - 33'd1;
      s1_lo_in = req_unsigned_lanes ? 33'd0 : ~s1_hi_in;
   end

   always_ff @(posedge clock) begin
      if (ctl.load1) begin
         s1_act_ff    <= s1_act_in;
         s1_mode_ff   <= s1_mode_in;
         s1_uns_ff    <= s1_uns_in;
         s1_sub_ff    <= req_subtract;
         s1_sub_lo_ff <= s1_sub_lo_in;
         s1_sub_hi_ff <= s1_sub_hi_in;
         s1_half_ff   <= s1_half_in;
         s1_hsat_ff   <= req_halfword_saturate;
         s1_a_ff      <= req_operand_a;
         s1_b_ff      <= req_operand_b;
         s1_sb_ff     <= s1_sb_in;
         s1_lb_ff     <= s1_lb_in;
         s1_hi_ff     <= s1_hi_in;
         s1_lo_ff     <= s1_lo_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: lane adders, scalar adder, saturation compares
   // ------------------------------------------------------------------
   action_type    s2_act_ff;
   lane_mode_type s2_mode_ff;
   logic          s2_uns_ff;
   logic          s2_sub_lo_ff, s2_sub_hi_ff;
   logic          s2_half_ff, s2_hsat_ff;
   logic [32:0]   s2_scal_ff, s2_scal_in;
   logic [9:0]    s2_braw_ff [4];
   logic [9:0]    s2_braw_in [4];
   logic [17:0]   s2_hraw_ff [2];
   logic [17:0]   s2_hraw_in [2];
   logic [31:0]   s2_b_ff;
   logic [31:0]   s2_hi_ff, s2_lo_ff;
   logic [2:0]    s2_gt_ff, s2_gt_in;    // {high half, low half, word}
   logic [2:0]    s2_lt_ff, s2_lt_in;
   logic          s1_sub_scal;
   logic signed [32:0] bw, bl, bh, hi_s, lo_s;

   always_comb begin
      s1_sub_scal = s1_sub_ff;
      s2_scal_in  = s1_sub_scal ? ({s1_a_ff[31], s1_a_ff} - {s1_sb_ff[31], s1_sb_ff})
                                : ({s1_a_ff[31], s1_a_ff} + {s1_sb_ff[31], s1_sb_ff});

      for (int i = 0; i < 4; i++) begin
         s2_braw_in[i] = byte_raw(s1_a_ff[8*i +: 8], s1_lb_ff[8*i +: 8], s1_uns_ff,
                                  (i < 2) ? s1_sub_lo_ff : s1_sub_hi_ff);
      end
      s2_hraw_in[0] = half_raw(s1_a_ff[15:0], s1_lb_ff[15:0], s1_uns_ff, s1_sub_lo_ff);
      s2_hraw_in[1] = half_raw(s1_a_ff[31:16], s1_lb_ff[31:16], s1_uns_ff, s1_sub_hi_ff);

      bw   = {s1_b_ff[31], s1_b_ff};
      bl   = {{17{s1_b_ff[15]}}, s1_b_ff[15:0]};
      bh   = {{17{s1_b_ff[31]}}, s1_b_ff[31:16]};
      hi_s = s1_hi_ff;
      lo_s = s1_lo_ff;
      s2_gt_in = {bh > hi_s, bl > hi_s, bw > hi_s};
      s2_lt_in = {bh < lo_s, bl < lo_s, bw < lo_s};
   end

   always_ff @(posedge clock) begin
      if (ctl.load2) begin
         s2_act_ff    <= s1_act_ff;
         s2_mode_ff   <= s1_mode_ff;
         s2_uns_ff    <= s1_uns_ff;
         s2_sub_lo_ff <= s1_sub_lo_ff;
         s2_sub_hi_ff <= s1_sub_hi_ff;
         s2_half_ff   <= s1_half_ff;
         s2_hsat_ff   <= s1_hsat_ff;
         s2_scal_ff   <= s2_scal_in;
         s2_braw_ff   <= s2_braw_in;
         s2_hraw_ff   <= s2_hraw_in;
         s2_b_ff      <= s1_b_ff;
         s2_hi_ff     <= s1_hi_ff[31:0];
         s2_lo_ff     <= s1_lo_ff[31:0];
         s2_gt_ff     <= s2_gt_in;
         s2_lt_ff     <= s2_lt_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: clamp and select into the output register
   // ------------------------------------------------------------------
   logic [31:0] res_ff, res_in;
   logic [3:0]  ge_ff, ge_in;
   logic        gew_ff, gew_in;
   logic [8:0]  bfin [4];
   logic [16:0] hfin [2];
   logic [31:0] lane_res;
   logic [3:0]  lane_ge;
   logic [15:0] sat_lo_half, sat_hi_half;
   logic [31:0] sat_res;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         bfin[i] = byte_fin(s2_braw_ff[i], s2_uns_ff,
                            (i < 2) ? s2_sub_lo_ff : s2_sub_hi_ff, s2_mode_ff);
      end
      hfin[0] = half_fin(s2_hraw_ff[0], s2_uns_ff, s2_sub_lo_ff, s2_mode_ff);
      hfin[1] = half_fin(s2_hraw_ff[1], s2_uns_ff, s2_sub_hi_ff, s2_mode_ff);

      if (s2_half_ff) begin
         lane_res = {hfin[1][15:0], hfin[0][15:0]};
         lane_ge  = {hfin[1][16], hfin[1][16], hfin[0][16], hfin[0][16]};
      end else begin
         lane_res = {bfin[3][7:0], bfin[2][7:0], bfin[1][7:0], bfin[0][7:0]};
         lane_ge  = {bfin[3][8], bfin[2][8], bfin[1][8], bfin[0][8]};
      end

      sat_lo_half = s2_gt_ff[1] ? s2_hi_ff[15:0] :
                    (s2_lt_ff[1] ? s2_lo_ff[15:0] : s2_b_ff[15:0]);
      sat_hi_half = s2_gt_ff[2] ? s2_hi_ff[15:0] :
                    (s2_lt_ff[2] ? s2_lo_ff[15:0] : s2_b_ff[31:16]);
      if (s2_hsat_ff) begin
         sat_res = {sat_hi_half, sat_lo_half};
      end else begin
         sat_res = s2_gt_ff[0] ? s2_hi_ff : (s2_lt_ff[0] ? s2_lo_ff : s2_b_ff);
      end

      res_in = 32'd0;
      ge_in  = 4'd0;
      gew_in = 1'b0;
      unique case (s2_act_ff)
         ACT_SCALAR: begin
            if (s2_scal_ff[32] != s2_scal_ff[31]) begin
               res_in = s2_scal_ff[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end else begin
               res_in = s2_scal_ff[31:0];
            end
         end
         ACT_LANE: begin
            res_in = lane_res;
            gew_in = (s2_mode_ff == MODE_PLAIN);
            ge_in  = gew_in ? lane_ge : 4'd0;
         end
         ACT_SAT:  res_in = sat_res;
         ACT_NONE: res_in = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.load3) begin
         res_ff <= res_in;
         ge_ff  <= ge_in;
         gew_ff <= gew_in;
      end
   end

   assign rsp_result     = res_ff;
   assign rsp_ge_flags   = ge_ff;
   assign rsp_ge_written = gew_ff;

endmodule
